// ===== rtl/hsmc_pkg.sv =====
// Shared types, constants and defaults of the headlight safety mode controller.
package hsmc_pkg;

  localparam int unsigned ADC_BITS_DEF  = 12;
  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned SW_W       = 3;
  localparam int unsigned THR_W      = 12;
  localparam int unsigned ERR_W      = 8;
  localparam int unsigned DLIM_W     = 16;
  localparam int unsigned TICK_W     = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

  typedef enum logic [1:0] {
    MODE_INIT     = 2'd0,
    MODE_NORMAL   = 2'd1,
    MODE_DEGRADED = 2'd2,
    MODE_SAFE     = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    LAMP_OFF  = 2'd0,
    LAMP_LOW  = 2'd1,
    LAMP_HIGH = 2'd2
  } lamp_e;

  localparam logic [SW_W-1:0] SW_OFF  = 3'd0;
  localparam logic [SW_W-1:0] SW_LOW  = 3'd1;
  localparam logic [SW_W-1:0] SW_HIGH = 3'd2;
  localparam logic [SW_W-1:0] SW_AUTO = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DARK_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERR_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEG_LIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TICK      = 3'd4;

  localparam logic [THR_W-1:0]  DARK_ON_RST   = 12'd800;
  localparam logic [THR_W-1:0]  BRIGHT_RST    = 12'd1000;
  localparam logic [ERR_W-1:0]  ERR_LIMIT_RST = 8'd3;
  localparam logic [DLIM_W-1:0] DEG_LIMIT_RST = 16'd100;
  localparam logic [TICK_W-1:0] TICK_RST      = 10'd10;

  typedef struct packed {
    logic [THR_W-1:0]  dark_on_threshold;
    logic [THR_W-1:0]  bright_off_threshold;
    logic [ERR_W-1:0]  error_limit;
    logic [DLIM_W-1:0] degraded_limit_ms;
    logic [TICK_W-1:0] tick_period_ms;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    lamp_e             lamp;
    logic              lit;
    logic [ERR_W-1:0]  err_count;
    logic              safe_latch;
  } ctl_state_t;

endpackage

// ===== rtl/hsmc_if.sv =====
// Request channel interfaces for the tick input, the result output and configuration.
interface hsmc_in_if #(
  parameter int unsigned ADC_BITS = hsmc_pkg::ADC_BITS_DEF
);
  import hsmc_pkg::*;

  logic                valid;
  logic                ready;
  logic [SW_W-1:0]     switch_code;
  logic                switch_ok;
  logic [ADC_BITS-1:0] ambient_level;
  logic                ambient_ok;
  logic                safe_request;

  modport source (
    output valid, switch_code, switch_ok, ambient_level, ambient_ok, safe_request,
    input  ready
  );
  modport sink (
    input  valid, switch_code, switch_ok, ambient_level, ambient_ok, safe_request,
    output ready
  );
endinterface

interface hsmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] lamp_command;
  logic [1:0] mode_now;
  logic       in_safe;
  logic       lamps_lit;

  modport source (
    output valid, lamp_command, mode_now, in_safe, lamps_lit,
    input  ready
  );
  modport sink (
    input  valid, lamp_command, mode_now, in_safe, lamps_lit,
    output ready
  );
endinterface

interface hsmc_cfg_if;
  import hsmc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/hsmc_step.sv =====
// Next-state logic of the mode machine and the lamp command for one control tick.
module hsmc_step #(
  parameter int unsigned ADC_BITS = hsmc_pkg::ADC_BITS_DEF
) (
  input  hsmc_pkg::cfg_t               cfg_i,
  input  hsmc_pkg::ctl_state_t         state_i,
  input  logic [hsmc_pkg::SW_W-1:0]    switch_code_i,
  input  logic                         switch_ok_i,
  input  logic [ADC_BITS-1:0]          ambient_level_i,
  input  logic                         ambient_ok_i,
  input  logic                         safe_request_i,
  input  logic                         deg_expired_i,
  output hsmc_pkg::ctl_state_t         state_o,
  output logic                         deg_enter_o
);
  import hsmc_pkg::*;

  localparam int unsigned CMP_W = (ADC_BITS > THR_W) ? ADC_BITS : THR_W;

  typedef struct packed {
    lamp_e lamp;
    logic  lit;
  } lamp_lit_t;

  logic [CMP_W-1:0] level;
  logic [CMP_W-1:0] dark_x;
  logic [CMP_W-1:0] bright_x;

  assign level    = CMP_W'(ambient_level_i);
  assign dark_x   = CMP_W'(cfg_i.dark_on_threshold);
  assign bright_x = CMP_W'(cfg_i.bright_off_threshold);

  // Hysteresis: a lit lamp turns off above the bright threshold, a dark one
  // turns on below the dark threshold. A failed sensor keeps everything.
  function automatic lamp_lit_t auto_logic(lamp_lit_t cur, logic amb_ok,
                                           logic [CMP_W-1:0] lvl,
                                           logic [CMP_W-1:0] dark,
                                           logic [CMP_W-1:0] bright);
    lamp_lit_t res;
    res = cur;
    if (amb_ok) begin
      if (cur.lit) begin
        if (lvl > bright) begin
          res.lamp = LAMP_OFF;
          res.lit  = 1'b0;
        end else begin
          res.lamp = LAMP_LOW;
        end
      end else begin
        if (lvl < dark) begin
          res.lamp = LAMP_LOW;
          res.lit  = 1'b1;
        end else begin
          res.lamp = LAMP_OFF;
        end
      end
    end
    return res;
  endfunction

  logic             all_ok;
  logic             trig;
  logic [ERR_W-1:0] err_inc;
  ctl_state_t       nxt;
  lamp_lit_t        ll_sw;
  lamp_lit_t        ll_fin;

  assign all_ok  = switch_ok_i & ambient_ok_i;
  assign trig    = state_i.safe_latch | safe_request_i;
  assign err_inc = (state_i.err_count != ERR_MAX) ? state_i.err_count + 1'b1
                                                  : state_i.err_count;

  always_comb begin
    nxt            = state_i;
    nxt.safe_latch = trig;
    deg_enter_o    = 1'b0;
    case (state_i.mode)
      MODE_INIT: begin
        if (trig) begin
          nxt.mode = MODE_SAFE;
        end else begin
          if (all_ok) begin
            nxt.mode      = MODE_NORMAL;
            nxt.err_count = '0;
          end
          nxt.lamp = LAMP_OFF;
        end
      end
      MODE_NORMAL: begin
        if (trig) begin
          nxt.mode = MODE_SAFE;
        end else if (!all_ok) begin
          nxt.err_count = err_inc;
          if (err_inc >= cfg_i.error_limit) begin
            nxt.mode    = MODE_DEGRADED;
            deg_enter_o = 1'b1;
          end
        end else begin
          nxt.err_count = '0;
        end
      end
      MODE_DEGRADED: begin
        if (trig) begin
          nxt.mode = MODE_SAFE;
        end else if (all_ok) begin
          nxt.mode      = MODE_NORMAL;
          nxt.err_count = '0;
        end else if (deg_expired_i) begin
          nxt.mode = MODE_SAFE;
        end
      end
      default: begin
        if (ambient_ok_i && (level >= dark_x)) begin
          nxt.lamp = LAMP_OFF;
        end else begin
          nxt.lamp = LAMP_LOW;
        end
      end
    endcase
  end

  always_comb begin
    ll_sw.lamp = nxt.lamp;
    ll_sw.lit  = nxt.lit;
    case (switch_code_i)
      SW_OFF: begin
        ll_sw.lamp = LAMP_OFF;
        ll_sw.lit  = 1'b0;
      end
      SW_LOW: begin
        ll_sw.lamp = LAMP_LOW;
        ll_sw.lit  = 1'b1;
      end
      SW_HIGH: begin
        ll_sw.lamp = LAMP_HIGH;
        ll_sw.lit  = 1'b1;
      end
      SW_AUTO: begin
        ll_sw = auto_logic(ll_sw, ambient_ok_i, level, dark_x, bright_x);
      end
      default: begin
        ll_sw = ll_sw;
      end
    endcase
    // In degraded mode an invalid switch falls back to automatic control.
    if ((nxt.mode == MODE_DEGRADED) && !switch_ok_i) begin
      ll_fin = auto_logic(ll_sw, ambient_ok_i, level, dark_x, bright_x);
    end else begin
      ll_fin = ll_sw;
    end
  end

  always_comb begin
    state_o = nxt;
    if (nxt.mode == MODE_INIT) begin
      state_o.lamp = LAMP_OFF;
    end else if (nxt.mode != MODE_SAFE) begin
      state_o.lamp = ll_fin.lamp;
      state_o.lit  = ll_fin.lit;
    end
  end

endmodule

// ===== rtl/headlight_safety_mode_controller_core.sv =====
// Top level of the headlight safety mode controller core.
// One request on the input channel is one control tick; each tick yields exactly
// one result request with the lamp command, the mode, the safe flag and the
// hysteresis lit flag. A tick is registered on acceptance and resolved, once the
// output side can take it, by single-pass logic against the mode state into the
// result register; the block takes one tick per clock cycle unless the output
// side stalls, and only then does the input register hold further ticks. The
// safe request latches until reset, and safe mode is final. The degraded
// timeout is measured on a millisecond clock that advances by the tick period
// each tick and wraps at TIME_BITS. Configuration writes are taken at any time,
// one per cycle, and are meant to happen only while no tick is in flight.
module headlight_safety_mode_controller_core #(
  parameter int unsigned ADC_BITS  = hsmc_pkg::ADC_BITS_DEF,
  parameter int unsigned TIME_BITS = hsmc_pkg::TIME_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsmc_in_if.sink      in_i,
  hsmc_out_if.source   out_o,
  hsmc_cfg_if.sink     cfg_i
);
  import hsmc_pkg::*;

  cfg_t                 cfg_q;
  ctl_state_t           ctl_q;
  ctl_state_t           ctl_d;
  logic [TIME_BITS-1:0] clock_q;
  logic [TIME_BITS-1:0] start_q;
  logic                 in_vld_q;
  logic                 out_vld_q;
  logic [SW_W-1:0]      sw_code_q;
  logic                 sw_ok_q;
  logic [ADC_BITS-1:0]  level_q;
  logic                 amb_ok_q;
  logic                 req_q;
  logic                 advance;
  logic                 in_take;
  logic                 deg_enter;
  logic                 deg_expired;
  logic [TIME_BITS-1:0] elapsed;

  assign advance     = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready  = ~in_vld_q | advance;
  assign in_take     = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign elapsed     = clock_q - start_q;
  assign deg_expired = elapsed > TIME_BITS'(cfg_q.degraded_limit_ms);

  hsmc_step #(
    .ADC_BITS (ADC_BITS)
  ) u_step (
    .cfg_i           (cfg_q),
    .state_i         (ctl_q),
    .switch_code_i   (sw_code_q),
    .switch_ok_i     (sw_ok_q),
    .ambient_level_i (level_q),
    .ambient_ok_i    (amb_ok_q),
    .safe_request_i  (req_q),
    .deg_expired_i   (deg_expired),
    .state_o         (ctl_d),
    .deg_enter_o     (deg_enter)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dark_on_threshold    <= DARK_ON_RST;
      cfg_q.bright_off_threshold <= BRIGHT_RST;
      cfg_q.error_limit          <= ERR_LIMIT_RST;
      cfg_q.degraded_limit_ms    <= DEG_LIMIT_RST;
      cfg_q.tick_period_ms       <= TICK_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_DARK_ON:   cfg_q.dark_on_threshold    <= cfg_i.data[THR_W-1:0];
        CFG_BRIGHT:    cfg_q.bright_off_threshold <= cfg_i.data[THR_W-1:0];
        CFG_ERR_LIMIT: cfg_q.error_limit          <= cfg_i.data[ERR_W-1:0];
        CFG_DEG_LIMIT: cfg_q.degraded_limit_ms    <= cfg_i.data[DLIM_W-1:0];
        CFG_TICK:      cfg_q.tick_period_ms       <= cfg_i.data[TICK_W-1:0];
        default:       cfg_q                      <= cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sw_code_q <= in_i.switch_code;
      sw_ok_q   <= in_i.switch_ok;
      level_q   <= ADC_BITS'(in_i.ambient_level);
      amb_ok_q  <= in_i.ambient_ok;
      req_q     <= in_i.safe_request;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.mode       <= MODE_INIT;
      ctl_q.lamp       <= LAMP_OFF;
      ctl_q.lit        <= 1'b0;
      ctl_q.err_count  <= '0;
      ctl_q.safe_latch <= 1'b0;
      clock_q          <= '0;
      start_q          <= '0;
    end else if (advance) begin
      ctl_q   <= ctl_d;
      clock_q <= clock_q + TIME_BITS'(cfg_q.tick_period_ms);
      if (deg_enter) begin
        start_q <= clock_q;
      end
    end
  end

  // The mode state is loaded together with the result, so it is the payload.
  assign out_o.valid        = out_vld_q;
  assign out_o.lamp_command = ctl_q.lamp;
  assign out_o.mode_now     = ctl_q.mode;
  assign out_o.in_safe      = (ctl_q.mode == MODE_SAFE);
  assign out_o.lamps_lit    = ctl_q.lit;

endmodule
